FILE: sv/pfde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared sizes, codes and types of the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

   // Screen size in pixels
   localparam int WIDTH       = 128;
   localparam int HEIGHT      = 64;
   localparam int PAGE_COUNT  = (HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PAGE_COUNT * WIDTH;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   // Request kinds as they arrive on tuser
   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_RECT  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Classified operation, as queued for the back end
   typedef enum logic [2:0] {
      OP_PIXEL,
      OP_FILL,
      OP_RECT,
      OP_READ,
      OP_REJECT,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [7:0]              row;
      logic [7:0]              col;
      logic [7:0]              row_end;
      logic [7:0]              col_end;
      logic [7:0]              thickness;
      logic                    color;
      logic [ADDR_W-1:0]       addr;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_FILL,
      ST_RING,
      ST_RECT_RD,
      ST_RECT_WR,
      ST_READ,
      ST_DONE
   } state_type;

   // Store byte holding pixel (r, c): page times width plus column
   function automatic logic [ADDR_W-1:0] byte_index(input logic [7:0] r, input logic [7:0] c);
      logic [17:0] full;
      full = 18'(r[7:3]) * 18'(WIDTH) + 18'(c);
      return full[ADDR_W-1:0];
   endfunction

endpackage

FILE: sv/pfde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_front
// Takes request words, checks their arguments and queues a classified command.
// ----------------------------------------------------------------------------
module pfde_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [1:0]                      req_tuser,   // kind
   input  logic [pfde_pkg::REQ_TDATA_W-1:0] req_tdata,  // row, col, row_end, col_end,
                                                         // thickness, color, byte_addr
   input  logic                            clearing,
   input  logic                            q_full,
   output logic                            q_push,
   output pfde_pkg::cmd_type               q_cmd
);
   import pfde_pkg::*;

   logic [7:0] row;
   logic [7:0] col;
   logic [7:0] row_end;
   logic [7:0] col_end;
   logic [7:0] thickness;
   logic       color;
   logic [9:0] byte_addr;
   logic       row_bad;
   logic       col_bad;
   logic       row_end_bad;
   logic       col_end_bad;
   logic       addr_bad;
   op_type     op;

   // field unpacking
   assign row       = req_tdata[7:0];
   assign col       = req_tdata[15:8];
   assign row_end   = req_tdata[23:16];
   assign col_end   = req_tdata[31:24];
   assign thickness = req_tdata[39:32];
   assign color     = req_tdata[40];
   assign byte_addr = req_tdata[50:41];

   // range checks
   assign row_bad     = {1'b0, row} >= 9'(HEIGHT);
   assign col_bad     = {1'b0, col} >= 9'(WIDTH);
   assign row_end_bad = {1'b0, row_end} >= 9'(HEIGHT);
   assign col_end_bad = {1'b0, col_end} >= 9'(WIDTH);
   assign addr_bad    = 14'(byte_addr) >= 14'(STORE_BYTES);

   // classify
   always_comb begin
      unique case (kind_type'(req_tuser))
         KIND_PIXEL: op = (row_bad || col_bad) ? OP_REJECT : OP_PIXEL;
         KIND_FILL:  op = OP_FILL;
         KIND_RECT: begin
            if (thickness == 8'd0)
               op = OP_NOP;
            else if (row_bad || col_bad || row_end_bad || col_end_bad ||
                     row > row_end || col > col_end)
               op = OP_REJECT;
            else
               op = OP_RECT;
         end
         KIND_READ:  op = addr_bad ? OP_REJECT : OP_READ;
         default:    op = OP_REJECT;
      endcase
   end

   assign q_cmd.op        = op;
   assign q_cmd.row       = row;
   assign q_cmd.col       = col;
   assign q_cmd.row_end   = row_end;
   assign q_cmd.col_end   = col_end;
   assign q_cmd.thickness = thickness;
   assign q_cmd.color     = color;
   assign q_cmd.addr      = ADDR_W'(byte_addr);

   // no words taken while the store is being cleared
   assign req_tready = !q_full && !clearing;
   assign q_push     = req_tvalid && req_tready;

endmodule

FILE: sv/pfde_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pfde_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfde_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pfde_pkg::cmd_type head_cmd
);
   import pfde_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command queue underflow");

endmodule

FILE: sv/pfde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_back
// Executes queued commands on the framebuffer store and registers the result.
// ----------------------------------------------------------------------------
module pfde_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  pfde_pkg::cmd_type               q_cmd,
   output logic                            q_pop,
   output logic                            clearing,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_tuser,   // status
   output logic [pfde_pkg::RSP_TDATA_W-1:0] rsp_tdata   // read_data
);
   import pfde_pkg::*;

   // framebuffer store
   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              wr_en;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [7:0]        top_ff, top_in;
   logic [7:0]        left_ff, left_in;
   logic [7:0]        bot_ff, bot_in;
   logic [7:0]        right_ff, right_in;
   logic [7:0]        rings_ff, rings_in;
   logic [7:0]        idx_ff, idx_in;
   logic              side_ff, side_in;
   logic              horiz_ff, horiz_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   logic [7:0]        pix_row;
   logic [7:0]        pix_col;
   logic [7:0]        pix_mask;
   logic [7:0]        pix_byte;
   logic              sweep_last;
   logic              out_free;

   // current pixel of the walk: vertical edges then horizontal edges
   always_comb begin
      if (horiz_ff) begin
         pix_row = side_ff ? bot_ff : top_ff;
         pix_col = idx_ff;
      end else begin
         pix_row = idx_ff;
         pix_col = side_ff ? right_ff : left_ff;
      end
      pix_mask = 8'(1) << pix_row[2:0];
      pix_byte = cmd_ff.color ? (rd_data_ff | pix_mask) : (rd_data_ff & ~pix_mask);
   end

   assign sweep_last = sweep_ff == ADDR_W'(STORE_BYTES - 1);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_addr    = (cmd_ff.op == OP_READ) ? cmd_ff.addr : byte_index(pix_row, pix_col);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      top_in        = top_ff;
      left_in       = left_ff;
      bot_in        = bot_ff;
      right_in      = right_ff;
      rings_in      = rings_ff;
      idx_in        = idx_ff;
      side_in       = side_ff;
      horiz_in      = horiz_ff;
      sweep_in      = sweep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = byte_index(pix_row, pix_col);
      wr_data       = pix_byte;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = 8'h00;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               top_in   = q_cmd.row;
               left_in  = q_cmd.col;
               bot_in   = q_cmd.row_end;
               right_in = q_cmd.col_end;
               rings_in = q_cmd.thickness;
               idx_in   = q_cmd.row;
               side_in  = 1'b0;
               horiz_in = 1'b0;
               sweep_in = '0;
               unique case (q_cmd.op)
                  OP_PIXEL: state_in = ST_PIX_RD;
                  OP_FILL:  state_in = ST_FILL;
                  OP_RECT:  state_in = ST_RING;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_PIX_RD: state_in = ST_PIX_WR;
         ST_PIX_WR: begin
            wr_en    = 1'b1;
            state_in = ST_DONE;
         end
         ST_FILL: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = {8{cmd_ff.color}};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last)
               state_in = ST_DONE;
         end
         ST_RING: begin
            // stop when rings run out or the box is two pixels or less across
            if (rings_ff == 8'd0 || (bot_ff - top_ff) <= 8'd1 ||
                (right_ff - left_ff) <= 8'd1) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = top_ff;
               side_in  = 1'b0;
               horiz_in = 1'b0;
               state_in = ST_RECT_RD;
            end
         end
         ST_RECT_RD: state_in = ST_RECT_WR;
         ST_RECT_WR: begin
            wr_en    = 1'b1;
            state_in = ST_RECT_RD;
            if (!side_ff) begin
               side_in = 1'b1;
            end else begin
               side_in = 1'b0;
               if (!horiz_ff) begin
                  if (idx_ff == bot_ff) begin
                     horiz_in = 1'b1;
                     idx_in   = left_ff;
                  end else begin
                     idx_in = idx_ff + 8'd1;
                  end
               end else if (idx_ff == right_ff) begin
                  // ring done: shrink the box
                  top_in   = top_ff + 8'd1;
                  left_in  = left_ff + 8'd1;
                  bot_in   = bot_ff - 8'd1;
                  right_in = right_ff - 8'd1;
                  rings_in = rings_ff - 8'd1;
                  state_in = ST_RING;
               end else begin
                  idx_in = idx_ff + 8'd1;
               end
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cmd_ff.op == OP_REJECT;
               rsp_data_in   = (cmd_ff.op == OP_READ) ? rd_data_ff : 8'h00;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      top_ff        <= top_in;
      left_ff       <= left_in;
      bot_ff        <= bot_in;
      right_ff      <= right_in;
      rings_ff      <= rings_in;
      idx_ff        <= idx_in;
      side_ff       <= side_in;
      horiz_ff      <= horiz_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign clearing   = state_ff == ST_CLEAR;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("command taken while busy");

   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RECT_WR |-> $past(state_ff) == ST_RECT_RD)
      else $error("rectangle write without preceding read");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_data_ff == 8'h00)
      else $error("rejected command returned data");

endmodule

FILE: sv/page_framebuffer_draw_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_core
// Monochrome page framebuffer with pixel, fill, rectangle and read commands.
// ----------------------------------------------------------------------------
// Each request word gives one response word. The front end checks arguments
// and queues up to two commands; the back end runs them one at a time on a
// single-port-write, registered-read byte store. A pixel command goes through
// take, read, write and respond; a read byte through take, read and respond;
// a rejected or empty command through take and respond; a fill writes one
// byte a cycle over all STORE_BYTES bytes. A rectangle reads and writes
// each pixel visited, each ring visiting 2 * (h + w) pixels, with a check
// before each ring and a final check. After reset the store is cleared one
// byte a cycle, during which no request is taken.
module page_framebuffer_draw_engine_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [1:0]                       req_tuser,  // kind
   input  logic [pfde_pkg::REQ_TDATA_W-1:0] req_tdata,  // row, col, row_end, col_end,
                                                         // thickness, color, byte_addr
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_tuser,  // status
   output logic [pfde_pkg::RSP_TDATA_W-1:0] rsp_tdata   // read_data
);
   import pfde_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    full;
   logic    head_valid;
   logic    clearing;

   // argument checks and classification
   pfde_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .clearing   (clearing),
      .q_full     (full),
      .q_push     (push),
      .q_cmd      (push_cmd)
   );

   // command queue
   pfde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // execution on the store
   pfde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (head_valid),
      .q_cmd      (head_cmd),
      .q_pop      (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
